[rtl/rasr_pkg.sv]
// ----------------------------------------------------------------------------
// rasr_pkg
// Shared types and constants of the radar ADC sample reorder block: register
// indexes, layout codes, reset values and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package rasr_pkg;

    // payload widths of the channels
    localparam int BYTE_W       = 8;
    localparam int WORD_W       = 16;
    localparam int RX_IDX_W     = 2;
    localparam int SAMPLE_IDX_W = 10;
    localparam int CHIRP_IDX_W  = 9;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;

    // words per group in the four-lane layout
    localparam int LANES = 4;

    // register reset values
    localparam int RX_COUNT_RESET     = 4;
    localparam int SAMPLE_COUNT_RESET = 256;
    localparam int CHIRP_COUNT_RESET  = 128;

    // register indexes on the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RX_COUNT     = 2'd0,
        REG_SAMPLE_COUNT = 2'd1,
        REG_CHIRP_COUNT  = 2'd2,
        REG_LAYOUT_MODE  = 2'd3
    } cfg_reg_t;

    // layout codes, anything above these gives no output
    typedef logic [1:0] layout_t;
    localparam layout_t LAYOUT_GROUPED   = 2'd0;
    localparam layout_t LAYOUT_FOUR_LANE = 2'd1;

    // one result item
    typedef struct packed {
        logic signed [WORD_W-1:0]       sample_value;
        logic        [RX_IDX_W-1:0]     rx_index;
        logic        [SAMPLE_IDX_W-1:0] sample_index;
        logic        [CHIRP_IDX_W-1:0]  chirp_index;
        logic                           is_imag;
    } result_t;

endpackage

`default_nettype wire

[rtl/rasr_cfg_if.sv]
// ----------------------------------------------------------------------------
// rasr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface rasr_cfg_if
    import rasr_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/rasr_byte_if.sv]
// ----------------------------------------------------------------------------
// rasr_byte_if
// Raw frame byte channel with its frame start flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface rasr_byte_if
    import rasr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

`default_nettype wire

[rtl/rasr_cube_if.sv]
// ----------------------------------------------------------------------------
// rasr_cube_if
// Cube entry channel: one ADC word with its destination in the data cube.
// ----------------------------------------------------------------------------
`default_nettype none

interface rasr_cube_if
    import rasr_pkg::*;
();
    logic                           valid;
    logic                           ready;
    logic signed [WORD_W-1:0]       sample_value;
    logic        [RX_IDX_W-1:0]     rx_index;
    logic        [SAMPLE_IDX_W-1:0] sample_index;
    logic        [CHIRP_IDX_W-1:0]  chirp_index;
    logic                           is_imag;

    modport source (output valid, output sample_value, output rx_index,
                    output sample_index, output chirp_index, output is_imag,
                    input ready);
    modport sink   (input valid, input sample_value, input rx_index,
                    input sample_index, input chirp_index, input is_imag,
                    output ready);
endinterface

`default_nettype wire

[rtl/rasr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// rasr_cfg_regs
// Configuration registers. Counts are held already clamped to 1..MAX so the
// address generator sees only legal values.
// ----------------------------------------------------------------------------
`default_nettype none

module rasr_cfg_regs
    import rasr_pkg::*;
#(
    parameter int MAX_RX      = 4,
    parameter int MAX_SAMPLES = 1024,
    parameter int MAX_CHIRPS  = 512
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    rasr_cfg_if.sink        cfg,
    output logic [$clog2(MAX_RX+1)-1:0]      rx_num,
    output logic [$clog2(MAX_SAMPLES+1)-1:0] sample_num,
    output logic [$clog2(MAX_CHIRPS+1)-1:0]  chirp_num,
    output layout_t                          layout
);
    localparam int NRW = $clog2(MAX_RX + 1);
    localparam int NSW = $clog2(MAX_SAMPLES + 1);
    localparam int NCW = $clog2(MAX_CHIRPS + 1);

    localparam int RX_RST  = (RX_COUNT_RESET > MAX_RX) ? MAX_RX : RX_COUNT_RESET;
    localparam int SMP_RST = (SAMPLE_COUNT_RESET > MAX_SAMPLES) ? MAX_SAMPLES
                                                                : SAMPLE_COUNT_RESET;
    localparam int CHP_RST = (CHIRP_COUNT_RESET > MAX_CHIRPS) ? MAX_CHIRPS
                                                              : CHIRP_COUNT_RESET;

    logic [NRW-1:0] rx_num_reg;
    logic [NSW-1:0] sample_num_reg;
    logic [NCW-1:0] chirp_num_reg;
    layout_t        layout_reg;

    logic [31:0]    rx_data;
    logic [31:0]    smp_data;
    logic [31:0]    chp_data;
    logic [31:0]    rx_clamp;
    logic [31:0]    smp_clamp;
    logic [31:0]    chp_clamp;

    // writes never stall
    assign cfg.ready = 1'b1;

    // register width first, then zero counts as one and large values saturate
    always_comb
    begin
        rx_data   = 32'(cfg.data[2:0]);
        smp_data  = 32'(cfg.data[10:0]);
        chp_data  = 32'(cfg.data[9:0]);
        rx_clamp  = (rx_data == 32'd0) ? 32'd1 :
                    (rx_data > 32'(MAX_RX)) ? 32'(MAX_RX) : rx_data;
        smp_clamp = (smp_data == 32'd0) ? 32'd1 :
                    (smp_data > 32'(MAX_SAMPLES)) ? 32'(MAX_SAMPLES) : smp_data;
        chp_clamp = (chp_data == 32'd0) ? 32'd1 :
                    (chp_data > 32'(MAX_CHIRPS)) ? 32'(MAX_CHIRPS) : chp_data;
    end

    // register file, one write per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_num_reg     <= NRW'(RX_RST);
            sample_num_reg <= NSW'(SMP_RST);
            chirp_num_reg  <= NCW'(CHP_RST);
            layout_reg     <= LAYOUT_FOUR_LANE;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_RX_COUNT:     rx_num_reg     <= NRW'(rx_clamp);
                REG_SAMPLE_COUNT: sample_num_reg <= NSW'(smp_clamp);
                REG_CHIRP_COUNT:  chirp_num_reg  <= NCW'(chp_clamp);
                REG_LAYOUT_MODE:  layout_reg     <= layout_t'(cfg.data[1:0]);
                default:          layout_reg     <= layout_reg;
            endcase
        end
    end

    assign rx_num     = rx_num_reg;
    assign sample_num = sample_num_reg;
    assign chirp_num  = chirp_num_reg;
    assign layout     = layout_reg;

`ifndef SYNTHESIS
    // rx and sample counts never leave their legal range; layout writes are kept
    assert property (@(posedge clk) disable iff (!rst_n)
        rx_num_reg != '0 && 32'(rx_num_reg) <= MAX_RX)
        else $error("rx count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_num_reg != '0 && 32'(sample_num_reg) <= MAX_SAMPLES)
        else $error("sample count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && cfg_reg_t'(cfg.index) == REG_LAYOUT_MODE |=>
        layout_reg == $past(cfg.data[1:0]))
        else $error("layout write lost");
`endif

endmodule

`default_nettype wire

[rtl/rasr_addr_gen.sv]
// ----------------------------------------------------------------------------
// rasr_addr_gen
// Byte pairing and cube position counters. One step per accepted byte; the
// result for a completed word is formed combinationally from the state and byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rasr_addr_gen
    import rasr_pkg::*;
#(
    parameter int MAX_RX      = 4,
    parameter int MAX_SAMPLES = 1024,
    parameter int MAX_CHIRPS  = 512
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               step,
    input  wire logic [BYTE_W-1:0]                  data_byte,
    input  wire logic                               frame_start,
    input  wire logic [$clog2(MAX_RX+1)-1:0]        rx_num,
    input  wire logic [$clog2(MAX_SAMPLES+1)-1:0]   sample_num,
    input  wire logic [$clog2(MAX_CHIRPS+1)-1:0]    chirp_num,
    input  wire layout_t                            layout,
    output logic                                    res_valid,
    output result_t                                 res
);
    localparam int NRW = $clog2(MAX_RX + 1);
    localparam int NSW = $clog2(MAX_SAMPLES + 1);
    localparam int NCW = $clog2(MAX_CHIRPS + 1);
    localparam int RPW = (MAX_RX > 1) ? $clog2(MAX_RX) : 1;
    localparam int SPW = $clog2(MAX_SAMPLES);
    localparam int CPW = (MAX_CHIRPS > 1) ? $clog2(MAX_CHIRPS) : 1;
    localparam int LPW = ($clog2(2 * MAX_RX) > 2) ? $clog2(2 * MAX_RX) : 2;

    typedef struct packed {
        logic [SPW-1:0] s;
        logic [RPW-1:0] r;
        logic [CPW-1:0] c;
        logic           wrap;
    } elem_t;

    // step one complex element: sample, then receiver, then chirp
    function automatic elem_t next_elem(elem_t e, logic [NSW-1:0] ns,
                                        logic [NRW-1:0] nr, logic [NCW-1:0] nc);
        elem_t          o;
        logic [SPW:0]   s_inc;
        logic [RPW:0]   r_inc;
        logic [CPW:0]   c_inc;
        logic           s_w;
        logic           r_w;
        logic           c_w;
        s_inc  = {1'b0, e.s} + 1'b1;
        r_inc  = {1'b0, e.r} + 1'b1;
        c_inc  = {1'b0, e.c} + 1'b1;
        s_w    = s_inc >= (SPW+1)'(ns);
        r_w    = r_inc >= (RPW+1)'(nr);
        c_w    = c_inc >= (CPW+1)'(nc);
        o.s    = s_w ? '0 : s_inc[SPW-1:0];
        o.r    = !s_w ? e.r : (r_w ? '0 : r_inc[RPW-1:0]);
        o.c    = !(s_w && r_w) ? e.c : (c_w ? '0 : c_inc[CPW-1:0]);
        o.wrap = s_w && r_w && c_w;
        return o;
    endfunction

    // sample and chirp range check for the grouped layout
    function automatic logic in_range_sc(elem_t e, logic [NSW-1:0] ns,
                                         logic [NCW-1:0] nc);
        return (SPW+1)'(e.s) < (SPW+1)'(ns) && (CPW+1)'(e.c) < (CPW+1)'(nc);
    endfunction

    logic [BYTE_W-1:0] low_reg,   low_next;
    logic              phase_reg, phase_next;
    logic [LPW-1:0]    lane_reg,  lane_next;
    logic [RPW-1:0]    rx_reg,    rx_next;
    logic [SPW-1:0]    smp_reg,   smp_next;
    logic [CPW-1:0]    chp_reg,   chp_next;
    logic              full_reg,  full_next;

    logic              eff_phase;
    logic [LPW-1:0]    cur_lane;
    elem_t             cur;
    logic              cur_full;
    elem_t             e1;
    elem_t             e2;
    logic [WORD_W-1:0] word;
    logic [NRW:0]      two_nr;
    logic [LPW:0]      lane_inc;
    logic [SPW:0]      g_s_inc;
    logic [CPW:0]      g_c_inc;
    logic              g_s_wrap;
    logic              g_c_wrap;
    logic              lane_lt_nr;
    logic              in_range;
    logic [1:0]        q_lane;

    // a frame start clears the position state before the byte is used
    always_comb
    begin
        eff_phase = frame_start ? 1'b0 : phase_reg;
        cur_lane  = frame_start ? '0 : lane_reg;
        cur.s     = frame_start ? '0 : smp_reg;
        cur.r     = frame_start ? '0 : rx_reg;
        cur.c     = frame_start ? '0 : chp_reg;
        cur.wrap  = 1'b0;
        cur_full  = frame_start ? 1'b0 : full_reg;
        word      = {data_byte, low_reg};
        e1        = next_elem(cur, sample_num, rx_num, chirp_num);
        e2        = next_elem(e1, sample_num, rx_num, chirp_num);
        two_nr    = {rx_num, 1'b0};
        lane_inc  = {1'b0, cur_lane} + 1'b1;
        g_s_inc   = {1'b0, cur.s} + 1'b1;
        g_c_inc   = {1'b0, cur.c} + 1'b1;
        g_s_wrap  = g_s_inc >= (SPW+1)'(sample_num);
        g_c_wrap  = g_c_inc >= (CPW+1)'(chirp_num);
        lane_lt_nr = (LPW+1)'(cur_lane) < (LPW+1)'(rx_num);
        in_range  = (SPW+1)'(cur.s) < (SPW+1)'(sample_num) &&
                    (RPW+1)'(cur.r) < (RPW+1)'(rx_num) &&
                    (CPW+1)'(cur.c) < (CPW+1)'(chirp_num);
        q_lane    = cur_lane[1:0];
    end

    // next state and result for one byte
    always_comb
    begin
        low_next   = low_reg;
        phase_next = !eff_phase;
        lane_next  = cur_lane;
        rx_next    = cur.r;
        smp_next   = cur.s;
        chp_next   = cur.c;
        full_next  = cur_full;
        res_valid  = 1'b0;
        res.sample_value = word;
        res.rx_index     = RX_IDX_W'(cur.r);
        res.sample_index = SAMPLE_IDX_W'(cur.s);
        res.chirp_index  = CHIRP_IDX_W'(cur.c);
        res.is_imag      = 1'b0;

        if (!eff_phase)
        begin
            low_next = data_byte;
        end
        else if (!cur_full && layout == LAYOUT_GROUPED)
        begin
            // grouped rows: real per receiver, then imaginary per receiver
            if ((LPW+1)'(cur_lane) >= (LPW+1)'(two_nr) || !in_range_sc(cur, sample_num,
                chirp_num))
            begin
                full_next = 1'b1;
            end
            else
            begin
                res_valid    = 1'b1;
                res.is_imag  = !lane_lt_nr;
                res.rx_index = lane_lt_nr ? RX_IDX_W'(cur_lane)
                                          : RX_IDX_W'(cur_lane - LPW'(rx_num));
                if ((LPW+1)'(lane_inc) >= (LPW+1)'(two_nr))
                begin
                    lane_next = '0;
                    if (g_s_wrap)
                    begin
                        smp_next = '0;
                        if (g_c_wrap)
                        begin
                            chp_next  = '0;
                            full_next = 1'b1;
                        end
                        else
                        begin
                            chp_next = g_c_inc[CPW-1:0];
                        end
                    end
                    else
                    begin
                        smp_next = g_s_inc[SPW-1:0];
                    end
                end
                else
                begin
                    lane_next = lane_inc[LPW-1:0];
                end
            end
        end
        else if (!cur_full && layout == LAYOUT_FOUR_LANE)
        begin
            // four lanes: imag, imag, real, real over elements 2g and 2g+1
            if (!in_range)
            begin
                full_next = 1'b1;
            end
            else
            begin
                res_valid   = !(q_lane[0] && e1.wrap);
                res.is_imag = !q_lane[1];
                if (q_lane[0])
                begin
                    res.rx_index     = RX_IDX_W'(e1.r);
                    res.sample_index = SAMPLE_IDX_W'(e1.s);
                    res.chirp_index  = CHIRP_IDX_W'(e1.c);
                end
                if (q_lane == 2'(LANES - 1))
                begin
                    lane_next = '0;
                    smp_next  = e1.wrap ? e1.s : e2.s;
                    rx_next   = e1.wrap ? e1.r : e2.r;
                    chp_next  = e1.wrap ? e1.c : e2.c;
                    full_next = e1.wrap || e2.wrap;
                end
                else
                begin
                    lane_next = LPW'(q_lane) + 1'b1;
                end
            end
        end
    end

    // position state, moves once per accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg   <= '0;
            phase_reg <= 1'b0;
            lane_reg  <= '0;
            rx_reg    <= '0;
            smp_reg   <= '0;
            chp_reg   <= '0;
            full_reg  <= 1'b0;
        end
        else if (step)
        begin
            low_reg   <= low_next;
            phase_reg <= phase_next;
            lane_reg  <= lane_next;
            rx_reg    <= rx_next;
            smp_reg   <= smp_next;
            chp_reg   <= chp_next;
            full_reg  <= full_next;
        end
    end

`ifndef SYNTHESIS
    // a word completes only on the second byte of a pair
    assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid |-> phase_reg && !frame_start && !full_reg)
        else $error("result without a completed word");
    // destination always inside the configured cube
    assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid |-> (NRW+1)'(res.rx_index) < (NRW+1)'(rx_num) &&
        (SAMPLE_IDX_W+2)'(res.sample_index) < (SAMPLE_IDX_W+2)'(sample_num) &&
        (CHIRP_IDX_W+2)'(res.chirp_index) < (CHIRP_IDX_W+2)'(chirp_num))
        else $error("destination outside the cube");
    // bytes alternate between low and high within a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        step && !frame_start |=> phase_reg != $past(phase_reg))
        else $error("byte pairing lost");
    // a frame start always leaves a pending low byte
    assert property (@(posedge clk) disable iff (!rst_n)
        step && frame_start |=> phase_reg && !full_reg)
        else $error("frame start did not restart pairing");
`endif

endmodule

`default_nettype wire

[rtl/radar_adc_sample_reorder.sv]
// ----------------------------------------------------------------------------
// radar_adc_sample_reorder
// Turns a raw radar capture byte stream into ADC words tagged with their
// receiver, sample, chirp and real/imaginary destination in the data cube.
//
//   channel | dir  | payload                                           | width
//   cfg     | in   | index, data                                       | 2, 11
//   frame   | in   | data_byte, frame_start                            | 8, 1
//   cube    | out  | sample_value, rx_index, sample_index, chirp_index,| 16,2,10,
//           |      | is_imag                                           | 9, 1
//
// One byte accepted per cycle unless the cube channel stalls; a result leaves
// after the high byte of its word through the input, then result register.
// Throughput is set by the single position-update step per byte.
// Reset clears the position counters and loads the register defaults.
// A stalled cube channel holds the result register; input is accepted while
// the input register is empty or the result register is free or being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module radar_adc_sample_reorder
    import rasr_pkg::*;
#(
    parameter int MAX_RX      = 4,
    parameter int MAX_SAMPLES = 1024,
    parameter int MAX_CHIRPS  = 512
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    rasr_cfg_if.sink     cfg,
    rasr_byte_if.sink    frame,
    rasr_cube_if.source  cube
);
    localparam int NRW = $clog2(MAX_RX + 1);
    localparam int NSW = $clog2(MAX_SAMPLES + 1);
    localparam int NCW = $clog2(MAX_CHIRPS + 1);

    logic [NRW-1:0]    rx_num;
    logic [NSW-1:0]    sample_num;
    logic [NCW-1:0]    chirp_num;
    layout_t           layout;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_start_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_res_reg;

    logic              advance;
    logic              step;
    logic              res_valid;
    result_t           res;

    // configuration registers
    rasr_cfg_regs #(
        .MAX_RX      (MAX_RX),
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_CHIRPS  (MAX_CHIRPS)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .rx_num     (rx_num),
        .sample_num (sample_num),
        .chirp_num  (chirp_num),
        .layout     (layout)
    );

    // handshake: the input stage moves when the result register can take
    assign advance     = !out_valid_reg || cube.ready;
    assign step        = in_valid_reg && advance;
    assign frame.ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (frame.ready)
        begin
            in_valid_reg <= frame.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready)
        begin
            in_byte_reg  <= frame.data_byte;
            in_start_reg <= frame.frame_start;
        end
    end

    // byte pairing and cube addressing
    rasr_addr_gen #(
        .MAX_RX      (MAX_RX),
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_CHIRPS  (MAX_CHIRPS)
    ) u_addr (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_byte   (in_byte_reg),
        .frame_start (in_start_reg),
        .rx_num      (rx_num),
        .sample_num  (sample_num),
        .chirp_num   (chirp_num),
        .layout      (layout),
        .res_valid   (res_valid),
        .res         (res)
    );

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = step && res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign cube.valid        = out_valid_reg;
    assign cube.sample_value = out_res_reg.sample_value;
    assign cube.rx_index     = out_res_reg.rx_index;
    assign cube.sample_index = out_res_reg.sample_index;
    assign cube.chirp_index  = out_res_reg.chirp_index;
    assign cube.is_imag      = out_res_reg.is_imag;

`ifndef SYNTHESIS
    // a held result is never overwritten while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !cube.ready |=> out_valid_reg && $stable(out_res_reg))
        else $error("stalled result overwritten");
    // the input stage never drops a byte while blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input byte lost under stall");
    // a result appears only after a stepped byte
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step))
        else $error("result without an input transfer");
`endif

endmodule

`default_nettype wire
